### rtl/core/csr_graph_builder_edge_query_defines.svh
// Assertion macros for the CSR graph builder.
// Needs nothing; included by the files that carry assertions.
`ifndef CSR_GRAPH_BUILDER_EDGE_QUERY_DEFINES_SVH
`define CSR_GRAPH_BUILDER_EDGE_QUERY_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CGBEQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define CGBEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/cgbeq_pkg.sv
// Shared types and constants for the CSR graph builder.
// No dependencies.
package cgbeq_pkg;

  localparam int MAX_V = 1024;
  localparam int MAX_E = 4096;

  localparam int VW  = 10;  // vertex index
  localparam int CW  = 11;  // vertex count
  localparam int TW  = 13;  // edge total
  localparam int OW  = 14;  // offsets, cursors
  localparam int EAW = 12;
  localparam int OAW = 11;
  localparam int CAW = 10;
  localparam int NAW = 13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NOBLD  = 2'd3;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_BSTART, OP_CLR,
    OP_CNT_RD, OP_CNT_EDGE, OP_CA_WR, OP_CB_RD, OP_CB_WR,
    OP_PINIT, OP_P_RD, OP_P_WR,
    OP_SINIT, OP_S_RD, OP_S_EDGE, OP_SA_WR, OP_SB_RD, OP_SB_WR,
    OP_SORT_INIT, OP_V_RD, OP_V_GET, OP_K_CHK, OP_K_KEY, OP_J_RD, OP_J_CMP,
    OP_FIN,
    OP_Q_CHK, OP_Q_R1, OP_Q_R2, OP_Q_R3, OP_Q_R4, OP_Q_BS, OP_Q_BCMP, OP_Q_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic busy;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic is_query;
    logic last;
    logic clr_last;
    logic edge_more;
    logic edge_in;
    logic vert_more;
    logic vsort_more;
    logic k_more;
    logic j_more;
    logic gt;
    logic q_ok;
    logic lt_more;
    logic lo_in;
  } dstat_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          found;
    logic          built;
    logic [TW-1:0] total;
  } res_t;

endpackage

### rtl/core/cgbeq_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module cgbeq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic [$clog2(D)-1:0] addr,
  input  logic                 we,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/core/cgbeq_dp.sv
// Datapath: edge store, offset, cursor and neighbour memories, counters.
// Depends on cgbeq_pkg and cgbeq_ram; driven by cgbeq_ctrl.
module cgbeq_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [cgbeq_pkg::CW-1:0] cfg_data,
  input  logic                    in_fire,
  input  logic                    mode,
  input  logic [cgbeq_pkg::VW-1:0] first_vertex,
  input  logic [cgbeq_pkg::VW-1:0] second_vertex,
  input  logic                    last_edge,
  input  cgbeq_pkg::op_t          op,
  output cgbeq_pkg::dstat_t       st,
  output cgbeq_pkg::res_t         res
);
  import cgbeq_pkg::*;

  logic [CW-1:0] vcount, bn, live;
  logic          built;
  logic [TW-1:0] etotal, eff_total;
  logic          il;
  logic [VW-1:0] iu, iv, ea, eb, key;
  logic [OW-1:0] idx, acc, acc_new, vstart, vend, k, j;
  logic [OW-1:0] ou, ou1, ov, base, deg, lo, hi, mid, mid_r, du, dv;
  logic [VW-1:0] target;
  logic [1:0]    rstat;
  logic          found;
  logic          ld_range, ld_full;

  logic [EAW-1:0] e_addr;  logic e_we;  logic [2*VW-1:0] e_wd, e_rd;
  logic [OAW-1:0] o_addr;  logic o_we;  logic [OW-1:0]   o_wd, o_rd;
  logic [CAW-1:0] c_addr;  logic c_we;  logic [OW-1:0]   c_wd, c_rd;
  logic [NAW-1:0] n_addr;  logic n_we;  logic [VW-1:0]   n_wd, n_rd;

  logic [VW-1:0] e_a, e_b;
  logic [OW-1:0] bn14;

  cgbeq_ram #(.W(2*VW), .D(MAX_E))   u_edge (.clk, .addr(e_addr), .we(e_we),
                                             .wdata(e_wd), .rdata(e_rd));
  cgbeq_ram #(.W(OW), .D(MAX_V + 1)) u_offs (.clk, .addr(o_addr), .we(o_we),
                                             .wdata(o_wd), .rdata(o_rd));
  cgbeq_ram #(.W(OW), .D(MAX_V))     u_curs (.clk, .addr(c_addr), .we(c_we),
                                             .wdata(c_wd), .rdata(c_rd));
  cgbeq_ram #(.W(VW), .D(2 * MAX_E)) u_nbr  (.clk, .addr(n_addr), .we(n_we),
                                             .wdata(n_wd), .rdata(n_rd));

  assign live      = (vcount > CW'(MAX_V)) ? CW'(MAX_V) : vcount;
  assign eff_total = built ? '0 : etotal;
  assign e_a       = e_rd[2*VW-1:VW];
  assign e_b       = e_rd[VW-1:0];
  assign bn14      = OW'(bn);
  assign acc_new   = acc + o_rd;
  assign ld_range  = ({1'b0, iu} >= live) || ({1'b0, iv} >= live);
  assign ld_full   = (eff_total == TW'(MAX_E));
  assign du        = ou1 - ou;
  assign dv        = o_rd - ov;
  assign mid       = lo + ((hi - lo) >> 1);

  always_comb begin
    st.is_query   = mode;
    st.last       = il;
    st.clr_last   = (idx == OW'(MAX_V));
    st.edge_more  = (idx < OW'(etotal));
    st.edge_in    = ({1'b0, e_a} < bn) && ({1'b0, e_b} < bn);
    st.vert_more  = (idx <= bn14);
    st.vsort_more = (idx < bn14);
    st.k_more     = (k < vend);
    st.j_more     = (j > vstart);
    st.gt         = (n_rd > key);
    st.q_ok       = built && ({1'b0, iu} < bn) && ({1'b0, iv} < bn);
    st.lt_more    = (lo < hi);
    st.lo_in      = (lo < deg);
  end

  assign res = '{status: rstat, found: found, built: built, total: etotal};

  always_comb begin
    e_addr = idx[EAW-1:0]; e_we = 1'b0; e_wd = {iu, iv};
    o_addr = '0;           o_we = 1'b0; o_wd = '0;
    c_addr = '0;           c_we = 1'b0; c_wd = '0;
    n_addr = '0;           n_we = 1'b0; n_wd = key;
    case (op)
      OP_LOAD: begin
        e_addr = eff_total[EAW-1:0];
        e_we   = !ld_range && !ld_full;
      end
      OP_CLR: begin
        o_addr = idx[OAW-1:0]; o_we = 1'b1;
      end
      OP_CNT_EDGE: o_addr = OAW'(e_a) + OAW'(1);
      OP_CA_WR: begin
        o_addr = OAW'(ea) + OAW'(1); o_we = 1'b1; o_wd = o_rd + OW'(1);
      end
      OP_CB_RD: o_addr = OAW'(eb) + OAW'(1);
      OP_CB_WR: begin
        o_addr = OAW'(eb) + OAW'(1); o_we = 1'b1; o_wd = o_rd + OW'(1);
      end
      OP_PINIT: c_we = 1'b1;
      OP_P_RD:  o_addr = idx[OAW-1:0];
      OP_P_WR: begin
        o_addr = idx[OAW-1:0]; o_we = 1'b1; o_wd = acc_new;
        c_addr = idx[CAW-1:0]; c_we = (idx < bn14); c_wd = acc_new;
      end
      OP_S_EDGE: c_addr = e_a;
      OP_SA_WR: begin
        n_addr = c_rd[NAW-1:0]; n_we = 1'b1; n_wd = eb;
        c_addr = ea; c_we = 1'b1; c_wd = c_rd + OW'(1);
      end
      OP_SB_RD: c_addr = eb;
      OP_SB_WR: begin
        n_addr = c_rd[NAW-1:0]; n_we = 1'b1; n_wd = ea;
        c_addr = eb; c_we = 1'b1; c_wd = c_rd + OW'(1);
      end
      OP_V_RD:  o_addr = idx[OAW-1:0] + OAW'(1);
      OP_K_CHK: n_addr = k[NAW-1:0];
      OP_J_RD: begin
        n_addr = st.j_more ? NAW'(j - OW'(1)) : j[NAW-1:0];
        n_we   = !st.j_more;
      end
      OP_J_CMP: begin
        n_addr = j[NAW-1:0]; n_we = 1'b1; n_wd = st.gt ? n_rd : key;
      end
      OP_Q_CHK: o_addr = OAW'(iu);
      OP_Q_R1:  o_addr = OAW'(iu) + OAW'(1);
      OP_Q_R2:  o_addr = OAW'(iv);
      OP_Q_R3:  o_addr = OAW'(iv) + OAW'(1);
      OP_Q_BS:  n_addr = st.lt_more ? NAW'(base + mid) : NAW'(base + lo);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= CW'(MAX_V);
      built  <= 1'b0;
      etotal <= '0;
      bn     <= '0;
    end else begin
      if (cfg_write) begin
        vcount <= cfg_data;
      end
      if (in_fire) begin
        il <= last_edge; iu <= first_vertex; iv <= second_vertex;
      end
      case (op)
        OP_LOAD: begin
          built <= 1'b0;
          found <= 1'b0;
          if (ld_range) begin
            rstat  <= ST_RANGE;
            etotal <= eff_total;
          end else if (ld_full) begin
            rstat  <= ST_FULL;
            etotal <= eff_total;
          end else begin
            rstat  <= ST_OK;
            etotal <= eff_total + TW'(1);
          end
        end
        OP_BSTART: begin
          bn  <= live;
          idx <= '0;
        end
        OP_CLR: idx <= st.clr_last ? '0 : idx + OW'(1);
        OP_CNT_EDGE, OP_S_EDGE: begin
          ea <= e_a; eb <= e_b; idx <= idx + OW'(1);
        end
        OP_PINIT: begin
          idx <= OW'(1); acc <= '0;
        end
        OP_P_WR: begin
          acc <= acc_new; idx <= idx + OW'(1);
        end
        OP_SINIT: idx <= '0;
        OP_SORT_INIT: begin
          idx <= '0; vend <= '0;
        end
        OP_V_GET: begin
          vstart <= vend; vend <= o_rd; k <= vend + OW'(1); idx <= idx + OW'(1);
        end
        OP_K_KEY: begin
          key <= n_rd; j <= k;
        end
        OP_J_RD: if (!st.j_more) k <= k + OW'(1);
        OP_J_CMP: begin
          if (st.gt) j <= j - OW'(1);
          else       k <= k + OW'(1);
        end
        OP_FIN: built <= 1'b1;
        OP_Q_CHK: begin
          found <= 1'b0;
          if (!built)         rstat <= ST_NOBLD;
          else if (!st.q_ok)  rstat <= ST_RANGE;
          else                rstat <= ST_OK;
        end
        OP_Q_R1: ou  <= o_rd;
        OP_Q_R2: ou1 <= o_rd;
        OP_Q_R3: ov  <= o_rd;
        OP_Q_R4: begin
          lo <= '0;
          if (dv < du) begin
            base <= ov; deg <= dv; hi <= dv; target <= iu;
          end else begin
            base <= ou; deg <= du; hi <= du; target <= iv;
          end
        end
        OP_Q_BS: if (st.lt_more) mid_r <= mid;
        OP_Q_BCMP: begin
          if (n_rd < target) lo <= mid_r + OW'(1);
          else               hi <= mid_r;
        end
        OP_Q_FIN: found <= (n_rd == target);
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/cgbeq_ctrl.sv
// Controller: sequences loads, the table build and queries.
// Depends on cgbeq_pkg; steers cgbeq_dp through op codes.
module cgbeq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  cgbeq_pkg::dstat_t st,
  output cgbeq_pkg::ctrl_t  ctl
);
  import cgbeq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_BSTART, S_CLR,
    S_CNT_RD, S_CNT_EDGE, S_CA_WR, S_CB_RD, S_CB_WR,
    S_PINIT, S_P_RD, S_P_WR,
    S_SINIT, S_S_RD, S_S_EDGE, S_SA_WR, S_SB_RD, S_SB_WR,
    S_SORT_INIT, S_V_RD, S_V_GET, S_K_CHK, S_K_KEY, S_J_RD, S_J_CMP, S_FIN,
    S_Q_CHK, S_Q_R1, S_Q_R2, S_Q_R3, S_Q_R4, S_Q_BS, S_Q_BCMP, S_Q_FIN,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:      if (in_fire) state <= st.is_query ? S_Q_CHK : S_LOAD;
        S_LOAD:      state <= st.last ? S_BSTART : S_DONE;
        S_BSTART:    state <= S_CLR;
        S_CLR:       if (st.clr_last) state <= S_CNT_RD;
        S_CNT_RD:    state <= st.edge_more ? S_CNT_EDGE : S_PINIT;
        S_CNT_EDGE:  state <= st.edge_in ? S_CA_WR : S_CNT_RD;
        S_CA_WR:     state <= S_CB_RD;
        S_CB_RD:     state <= S_CB_WR;
        S_CB_WR:     state <= S_CNT_RD;
        S_PINIT:     state <= S_P_RD;
        S_P_RD:      state <= st.vert_more ? S_P_WR : S_SINIT;
        S_P_WR:      state <= S_P_RD;
        S_SINIT:     state <= S_S_RD;
        S_S_RD:      state <= st.edge_more ? S_S_EDGE : S_SORT_INIT;
        S_S_EDGE:    state <= st.edge_in ? S_SA_WR : S_S_RD;
        S_SA_WR:     state <= S_SB_RD;
        S_SB_RD:     state <= S_SB_WR;
        S_SB_WR:     state <= S_S_RD;
        S_SORT_INIT: state <= S_V_RD;
        S_V_RD:      state <= st.vsort_more ? S_V_GET : S_FIN;
        S_V_GET:     state <= S_K_CHK;
        S_K_CHK:     state <= st.k_more ? S_K_KEY : S_V_RD;
        S_K_KEY:     state <= S_J_RD;
        S_J_RD:      state <= st.j_more ? S_J_CMP : S_K_CHK;
        S_J_CMP:     state <= st.gt ? S_J_RD : S_K_CHK;
        S_FIN:       state <= S_DONE;
        S_Q_CHK:     state <= st.q_ok ? S_Q_R1 : S_DONE;
        S_Q_R1:      state <= S_Q_R2;
        S_Q_R2:      state <= S_Q_R3;
        S_Q_R3:      state <= S_Q_R4;
        S_Q_R4:      state <= S_Q_BS;
        S_Q_BS:      state <= st.lt_more ? S_Q_BCMP : (st.lo_in ? S_Q_FIN : S_DONE);
        S_Q_BCMP:    state <= S_Q_BS;
        S_Q_FIN:     state <= S_DONE;
        S_DONE:      if (out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.busy     = (state != S_IDLE);
    ctl.out_load = (state == S_DONE) && out_free;
    unique case (state)
      S_LOAD:      ctl.op = OP_LOAD;
      S_BSTART:    ctl.op = OP_BSTART;
      S_CLR:       ctl.op = OP_CLR;
      S_CNT_RD:    ctl.op = OP_CNT_RD;
      S_CNT_EDGE:  ctl.op = OP_CNT_EDGE;
      S_CA_WR:     ctl.op = OP_CA_WR;
      S_CB_RD:     ctl.op = OP_CB_RD;
      S_CB_WR:     ctl.op = OP_CB_WR;
      S_PINIT:     ctl.op = OP_PINIT;
      S_P_RD:      ctl.op = OP_P_RD;
      S_P_WR:      ctl.op = OP_P_WR;
      S_SINIT:     ctl.op = OP_SINIT;
      S_S_RD:      ctl.op = OP_S_RD;
      S_S_EDGE:    ctl.op = OP_S_EDGE;
      S_SA_WR:     ctl.op = OP_SA_WR;
      S_SB_RD:     ctl.op = OP_SB_RD;
      S_SB_WR:     ctl.op = OP_SB_WR;
      S_SORT_INIT: ctl.op = OP_SORT_INIT;
      S_V_RD:      ctl.op = OP_V_RD;
      S_V_GET:     ctl.op = OP_V_GET;
      S_K_CHK:     ctl.op = OP_K_CHK;
      S_K_KEY:     ctl.op = OP_K_KEY;
      S_J_RD:      ctl.op = OP_J_RD;
      S_J_CMP:     ctl.op = OP_J_CMP;
      S_FIN:       ctl.op = OP_FIN;
      S_Q_CHK:     ctl.op = OP_Q_CHK;
      S_Q_R1:      ctl.op = OP_Q_R1;
      S_Q_R2:      ctl.op = OP_Q_R2;
      S_Q_R3:      ctl.op = OP_Q_R3;
      S_Q_R4:      ctl.op = OP_Q_R4;
      S_Q_BS:      ctl.op = OP_Q_BS;
      S_Q_BCMP:    ctl.op = OP_Q_BCMP;
      S_Q_FIN:     ctl.op = OP_Q_FIN;
      default:     ctl.op = OP_NOP;
    endcase
  end
endmodule

### rtl/core/csr_graph_builder_edge_query.sv
// CSR graph builder with edge queries: top level.
// Depends on cgbeq_pkg, cgbeq_ctrl, cgbeq_dp and the assertion macro header.
//
// Loads undirected edges into a 4096-word edge store; the load word marked
// last_edge builds a compressed sparse row table (degree count, prefix sum,
// scatter, per-vertex insertion sort), after which query words report whether
// an edge exists by binary search over the shorter neighbour list. One word
// in, one result word out, one item at a time. A query reads the offsets of
// both vertices, then binary-searches the shorter neighbour list through the
// registered reads of the offset and neighbour memories. The build item adds
// a clearing pass over all 1025 offset memory words, a pass over the stored
// edges for the degree count and again for the scatter, a pass over the
// vertices for the prefix sum, and the insertion sort; all of it goes
// through single-port memories one access per cycle. A finished result is
// held in an output register, so the next word is taken while it waits.
// vertex_count may be written only while idle.
module csr_graph_builder_edge_query (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [cgbeq_pkg::CW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [cgbeq_pkg::VW-1:0] first_vertex,
  input  logic [cgbeq_pkg::VW-1:0] second_vertex,
  input  logic                     last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic                     edge_found,
  output logic                     graph_ready,
  output logic [cgbeq_pkg::TW-1:0] edges_held
);
  import cgbeq_pkg::*;
  `include "csr_graph_builder_edge_query_defines.svh"

  ctrl_t  ctl;
  dstat_t st;
  res_t   res;
  logic   in_fire, out_free;

  // Busy from accept until the result word is placed in the output register.
  assign in_stall = ctl.busy;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  cgbeq_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .st, .ctl
  );

  cgbeq_dp u_dp (
    .clk, .rst, .cfg_write, .cfg_data, .in_fire,
    .mode, .first_vertex, .second_vertex, .last_edge,
    .op(ctl.op), .st, .res
  );

  // Output register: holds the result word until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= res.status;
      edge_found  <= res.found;
      graph_ready <= res.built;
      edges_held  <= res.total;
    end
  end

  `CGBEQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_fire, in_stall)
  `CGBEQ_ASSERT_NOW(a_found_is_ok, clk, rst, out_valid && edge_found,
                    status == ST_OK && graph_ready)
  `CGBEQ_ASSERT_NOW(a_nobuild_not_ready, clk, rst, out_valid && status == ST_NOBLD,
                    !graph_ready)
endmodule

### verif/tb_top.sv
// Self-checking bench for the CSR graph builder with edge queries.
// Needs cgbeq_pkg and csr_graph_builder_edge_query; nothing else.
`timescale 1ns / 100ps

module tb_top;
  import cgbeq_pkg::*;

  typedef struct {
    bit                mode;
    logic [VW-1:0]     u;
    logic [VW-1:0]     v;
    bit                last;
  } graph_word_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          mode = 1'b0;
  logic [VW-1:0] first_vertex = '0;
  logic [VW-1:0] second_vertex = '0;
  logic          last_edge = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    status;
  logic          edge_found;
  logic          graph_ready;
  logic [TW-1:0] edges_held;

  csr_graph_builder_edge_query DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .first_vertex(first_vertex), .second_vertex(second_vertex),
    .last_edge(last_edge),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .edge_found(edge_found), .graph_ready(graph_ready),
    .edges_held(edges_held)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Words waiting to be driven, and results the block still owes us.
  graph_word_t word_q[$];
  res_t        owed_q[$];

  int unsigned idle_in_pct  = 0;
  int unsigned idle_out_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;

  // ---------------------------------------------------------------------------
  // Shadow of the block's state. Only the stored edge list is kept: a query
  // hits when some edge inside the table matches the pair in either order,
  // which is what a binary search over the sorted shorter list answers.
  // ---------------------------------------------------------------------------
  logic [VW-1:0] shadow_a[MAX_E];
  logic [VW-1:0] shadow_b[MAX_E];
  int unsigned   shadow_total = 0;
  bit            shadow_built = 1'b0;
  int unsigned   shadow_built_verts = 0;
  logic [CW-1:0] shadow_vcount = CW'(MAX_V);

  function automatic int unsigned live_verts();
    return (shadow_vcount > MAX_V) ? MAX_V : shadow_vcount;
  endfunction

  function automatic res_t csr_predict(graph_word_t w);
    res_t        r;
    int unsigned n;
    r = '0;
    r.status = ST_OK;
    if (!w.mode) begin
      // a load after a finished build starts a fresh graph
      if (shadow_built) begin
        shadow_built = 1'b0;
        shadow_total = 0;
      end
      n = live_verts();
      if (w.u >= n || w.v >= n) begin
        r.status = ST_RANGE;
      end else if (shadow_total >= MAX_E) begin
        r.status = ST_FULL;
      end else begin
        shadow_a[shadow_total] = w.u;
        shadow_b[shadow_total] = w.v;
        shadow_total++;
      end
      if (w.last) begin
        shadow_built_verts = n;
        shadow_built = 1'b1;
      end
    end else begin
      if (!shadow_built) begin
        r.status = ST_NOBLD;
      end else if (w.u >= shadow_built_verts || w.v >= shadow_built_verts) begin
        r.status = ST_RANGE;
      end else begin
        for (int i = 0; i < shadow_total; i++) begin
          if (shadow_a[i] < shadow_built_verts && shadow_b[i] < shadow_built_verts &&
              ((shadow_a[i] == w.u && shadow_b[i] == w.v) ||
               (shadow_a[i] == w.v && shadow_b[i] == w.u)))
            r.found = 1'b1;
        end
      end
    end
    r.built = shadow_built;
    r.total = TW'(shadow_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: the word on the bus is taken when valid is high and stall low.
  // Prediction happens on acceptance; the next word is only presented once
  // the current one has gone, so a stalled payload never moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    graph_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        w.mode = mode;
        w.u    = first_vertex;
        w.v    = second_vertex;
        w.last = last_edge;
        owed_q.push_back(csr_predict(w));
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          w = word_q.pop_front();
          in_valid      <= 1'b1;
          mode          <= w.mode;
          first_vertex  <= w.u;
          second_vertex <= w.v;
          last_edge     <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest one owed.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected result word", 0, 1);
        end else begin
          want = owed_q.pop_front();
          if (status !== want.status)
            report_mismatch("status", want.status, status);
          if (edge_found !== want.found)
            report_mismatch("edge_found", want.found, edge_found);
          if (graph_ready !== want.built)
            report_mismatch("graph_ready", want.built, graph_ready);
          if (edges_held !== want.total)
            report_mismatch("edges_held", want.total, edges_held);
        end
      end
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(bit m, int unsigned a, int unsigned b, bit lst);
    graph_word_t w;
    w.mode = m;
    w.u    = VW'(a);
    w.v    = VW'(b);
    w.last = lst;
    word_q.push_back(w);
  endtask

  // Sender holds off until the block has returned everything.
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || owed_q.size() != 0);
  endtask

  task automatic write_vcount(int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= CW'(val);
    shadow_vcount = CW'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int unsigned pick_vertex(int unsigned n);
    if (n == 0 || $urandom_range(9) == 0)
      return $urandom_range(MAX_V - 1);
    return $urandom_range(n - 1);
  endfunction

  // One graph: loads with a few stray queries, the last one marked, then
  // queries that mostly ask about edges that were loaded.
  task automatic random_graph(int unsigned nloads, int unsigned nqueries);
    int unsigned pa[$];
    int unsigned pb[$];
    int unsigned n, a, b, k;
    n = live_verts();
    for (int i = 0; i < nloads; i++) begin
      a = pick_vertex(n);
      b = pick_vertex(n);
      pa.push_back(a);
      pb.push_back(b);
      push_word(1'b0, a, b, i == nloads - 1);
      if ($urandom_range(19) == 0)
        push_word(1'b1, pick_vertex(n), pick_vertex(n), $urandom_range(1));
    end
    for (int i = 0; i < nqueries; i++) begin
      k = $urandom_range(9);
      if (k < 6) begin
        k = $urandom_range(pa.size() - 1);
        if ($urandom_range(1))
          push_word(1'b1, pa[k], pb[k], $urandom_range(1));
        else
          push_word(1'b1, pb[k], pa[k], $urandom_range(1));
      end else begin
        push_word(1'b1, pick_vertex(n), pick_vertex(n), $urandom_range(1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int unsigned vc_sweep[6] = '{MAX_V, 16, 1, 2047, 0, 300};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: corner vertices, self-loop, duplicates, last mark on a query,
    // query before build, and a fresh graph after a build.
    write_vcount(MAX_V);
    push_word(1'b1, 0, 0, 1'b0);
    push_word(1'b0, 0, 1023, 1'b0);
    push_word(1'b0, 1023, 1023, 1'b0);
    push_word(1'b0, 5, 5, 1'b0);
    push_word(1'b0, 5, 5, 1'b0);
    push_word(1'b1, 2, 3, 1'b1);
    push_word(1'b0, 3, 7, 1'b1);
    push_word(1'b1, 1023, 0, 1'b0);
    push_word(1'b1, 0, 1023, 1'b0);
    push_word(1'b1, 1023, 1023, 1'b0);
    push_word(1'b1, 5, 5, 1'b0);
    push_word(1'b1, 7, 3, 1'b0);
    push_word(1'b1, 3, 3, 1'b0);
    push_word(1'b1, 0, 0, 1'b1);
    push_word(1'b1, 682, 341, 1'b0);
    push_word(1'b0, 1, 2, 1'b0);
    push_word(1'b1, 1, 2, 1'b0);
    push_word(1'b0, 2, 1, 1'b1);
    push_word(1'b1, 1, 2, 1'b0);
    push_word(1'b1, 2, 2, 1'b0);
    drain();

    // Random: vertex count sweep, idling profile changes every two settings.
    for (int s = 0; s < 6; s++) begin
      idle_in_pct  = (s < 2) ? 12 : (s < 4) ? 83 : 0;
      idle_out_pct = (s < 2) ? 83 : (s < 4) ? 12 : 0;
      drain();
      write_vcount(vc_sweep[s]);
      for (int g = 0; g < 3; g++) begin
        random_graph($urandom_range(30, 1), $urandom_range(25, 5));
        if (g == 1)
          drain();
      end
    end

    // Vertex count lowered between the loads and the build.
    drain();
    idle_in_pct  = 0;
    idle_out_pct = 0;
    write_vcount(64);
    for (int i = 0; i < 15; i++)
      push_word(1'b0, $urandom_range(63), $urandom_range(63), 1'b0);
    push_word(1'b0, 1, 2, 1'b0);
    push_word(1'b0, 40, 50, 1'b0);
    drain();
    write_vcount(8);
    push_word(1'b0, 3, 4, 1'b1);
    push_word(1'b1, 2, 1, 1'b0);
    push_word(1'b1, 50, 40, 1'b0);
    push_word(1'b1, 4, 3, 1'b0);
    for (int i = 0; i < 10; i++)
      push_word(1'b1, $urandom_range(9), $urandom_range(9), 1'b0);
    drain();

    // One more graph over the full vertex range to finish.
    write_vcount(MAX_V);
    random_graph(24, 12);
    drain();

    repeat (200) @(posedge clk);
    $display("Covered %0d words and %0d results: vertex counts 0 to 2047,", words_sent,
             results_seen);
    $display("late count change, self-loops, duplicates, early queries.");
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (owed_q.size() != 0)
        $display("%0d result words never arrived", owed_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Timed out with %0d result words outstanding", owed_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
